// File: src/wwpd_pkg.sv
// Shared constants, types and codes of the weighted window peak detector.
package wwpd_pkg;

    localparam int MAX_LEN   = 256;
    localparam int WINDOW    = 7;
    localparam int SAMPLE_W  = 16;
    localparam int W_BITS    = 4;
    localparam int TAPS_W    = WINDOW * W_BITS;
    localparam int MARGIN_W  = 16;
    localparam int INDEX_W   = 8;
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int COUNT_W   = $clog2(MAX_LEN + 1);
    localparam int TAP_W     = $clog2(WINDOW);
    localparam int CENTRE    = WINDOW / 2;
    // Centre of the window ending two samples back, relative to the current position.
    localparam int CENTRE_LAG = 2 + (WINDOW - 1) - CENTRE;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TAPS_W;
    // centre - margin - sample, signed.
    localparam int DIFF_W = SAMPLE_W + 2;
    localparam int ACC_W  = SAMPLE_W + 1 + W_BITS + TAP_W + 1;

    localparam logic [TAPS_W-1:0]   TAPS_RESET   = TAPS_W'(54591811);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(2048);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_WEIGHTS = 1'b0,
        CFG_PEAK_MARGIN = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic mac_clr;
        logic mac_en;
        logic emit;
    } t_ctl;

endpackage

// File: src/wwpd_if.sv
// Handshake channels of the weighted window peak detector.
interface wwpd_smp_if;
    logic                          valid;
    logic                          ready;
    logic [wwpd_pkg::SAMPLE_W-1:0] sample;
    logic                          last;
    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wwpd_res_if;
    logic                         valid;
    logic                         ready;
    logic                         is_peak;
    logic [wwpd_pkg::INDEX_W-1:0] peak_index;
    logic                         end_of_profile;
    logic [wwpd_pkg::COUNT_W-1:0] peak_total;
    modport source (output valid, output is_peak, output peak_index,
                    output end_of_profile, output peak_total, input ready);
    modport sink   (input valid, input is_peak, input peak_index,
                    input end_of_profile, input peak_total, output ready);
endinterface

interface wwpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wwpd_pkg::CFG_IDX_W-1:0]  index;
    logic [wwpd_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/wwpd_mac.sv
// Shared multiply-accumulate unit: adds w * (centre - margin - sample) per tap.
module wwpd_mac (
    input  logic                            i_clk,
    input  wwpd_pkg::t_ctl                  i_ctl,
    input  logic [wwpd_pkg::W_BITS-1:0]     i_weight,
    input  logic [wwpd_pkg::SAMPLE_W-1:0]   i_centre,
    input  logic [wwpd_pkg::MARGIN_W-1:0]   i_margin,
    input  logic [wwpd_pkg::SAMPLE_W-1:0]   i_sample,
    output logic signed [wwpd_pkg::ACC_W-1:0] o_acc
);

    logic signed [wwpd_pkg::DIFF_W-1:0]              diff;
    logic signed [wwpd_pkg::DIFF_W+wwpd_pkg::W_BITS:0] prod;
    logic signed [wwpd_pkg::ACC_W-1:0]               r_acc;

    always_comb begin
        diff = $signed({2'b00, i_centre}) - $signed({2'b00, i_margin})
             - $signed({2'b00, i_sample});
        prod = $signed({1'b0, i_weight}) * diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_clr) begin
            r_acc <= '0;
        end else if (i_ctl.mac_en) begin
            r_acc <= r_acc + wwpd_pkg::ACC_W'(prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// File: src/wwpd_ctrl.sv
// Sequencer: takes a sample, steps the shared unit over the taps if due, emits.
module wwpd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_need_mac,
    input  logic                          i_emit_ok,
    output wwpd_pkg::t_ctl                o_ctl,
    output logic [wwpd_pkg::TAP_W-1:0]    o_tap
);

    wwpd_pkg::t_state r_state, n_state;
    logic [wwpd_pkg::TAP_W-1:0] r_tap, n_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wwpd_pkg::S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_ctl   = '0;
        case (r_state)
            wwpd_pkg::S_IDLE: begin
                // Hold off transfers while reset is asserted.
                o_ctl.in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_ctl.accept  = 1'b1;
                    o_ctl.mac_clr = 1'b1;
                    n_tap         = '0;
                    n_state       = i_need_mac ? wwpd_pkg::S_MAC : wwpd_pkg::S_EMIT;
                end
            end
            wwpd_pkg::S_MAC: begin
                o_ctl.mac_en = 1'b1;
                n_tap        = r_tap + 1'b1;
                if (r_tap == wwpd_pkg::TAP_W'(wwpd_pkg::WINDOW - 1)) begin
                    n_state = wwpd_pkg::S_EMIT;
                end
            end
            wwpd_pkg::S_EMIT: begin
                if (i_emit_ok) begin
                    o_ctl.emit = 1'b1;
                    n_state    = wwpd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wwpd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_tap = r_tap;

endmodule

// File: src/weighted_window_peak_detector_unit.sv
// Top level of the weighted window peak detector.
// Usage:
//   i_smp  : sample channel (8.8 unsigned profile value plus last mark).
//   o_res  : result channel (is_peak, peak_index, end_of_profile, peak_total).
//   i_cfg  : register writes, index 0 = tap_weights, 1 = peak_margin;
//            ready whenever reset is released, write only while the block is idle.
// Sequence: a sample transfer is followed by the seven taps in the shared
//   multiply-accumulate unit (one tap per cycle) once the window is full, and
//   then the emit step; ready returns after that. The accumulate is skipped
//   when the window is not yet full or the profile is past its cut.
// A peak is confirmed two samples after its window closes, so a result shows
//   up on the transfer of that later sample, or on the last sample of a
//   profile. Results sit in an output register; a new sample is taken while
//   one waits there. If the receiver stalls with a result still held and the
//   next one is due, the block holds in its emit step until the slot frees.
// Reset: synchronous, active low; restores default weights {3,4,1,0,1,4,3}
//   and margin 8.0, clears profile position, peak count and pending verdicts.
//   Both input channels hold ready low while reset is asserted.
module weighted_window_peak_detector_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wwpd_smp_if.sink     i_smp,
    wwpd_res_if.source   o_res,
    wwpd_cfg_if.sink     i_cfg
);

    // Configuration registers.
    logic [wwpd_pkg::TAPS_W-1:0]   r_taps;
    logic [wwpd_pkg::MARGIN_W-1:0] r_margin;

    // Sample window, oldest in entry zero.
    logic [wwpd_pkg::SAMPLE_W-1:0] r_win [wwpd_pkg::WINDOW];

    // Profile state.
    logic [wwpd_pkg::POS_W-1:0]   r_pos;
    logic [wwpd_pkg::COUNT_W-1:0] r_peaks;
    logic [1:0]                   r_pend;

    // Per-sample context held across the accumulate.
    logic                         r_conf;
    logic                         r_last;
    logic [wwpd_pkg::INDEX_W-1:0] r_centre;

    // Output register.
    logic                         r_out_valid;
    logic                         r_is_peak;
    logic [wwpd_pkg::INDEX_W-1:0] r_index;
    logic                         r_eop;
    logic [wwpd_pkg::COUNT_W-1:0] r_total;

    wwpd_pkg::t_ctl                     ctl;
    logic [wwpd_pkg::TAP_W-1:0]         tap;
    logic signed [wwpd_pkg::ACC_W-1:0]  acc;
    logic                               active;
    logic                               need_mac;
    logic                               need_out;
    logic                               emit_ok;
    logic                               verdict;
    logic [wwpd_pkg::POS_W-1:0]         centre_pos;

    assign active   = r_pos < wwpd_pkg::POS_W'(wwpd_pkg::MAX_LEN);
    assign need_mac = active && (r_pos >= wwpd_pkg::POS_W'(wwpd_pkg::WINDOW - 1));
    assign need_out = r_conf | r_last;
    assign emit_ok  = !need_out || !r_out_valid || o_res.ready;
    // Positive sum of w * (centre - margin - x) means centre beats mean + margin;
    // a zero weight sum leaves the sum at zero, so no peak.
    assign verdict  = !acc[wwpd_pkg::ACC_W-1] && (acc != '0);
    assign centre_pos = r_pos - wwpd_pkg::POS_W'(wwpd_pkg::CENTRE_LAG);

    wwpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_need_mac (need_mac),
        .i_emit_ok  (emit_ok),
        .o_ctl      (ctl),
        .o_tap      (tap)
    );

    wwpd_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_weight (r_taps[tap*wwpd_pkg::W_BITS +: wwpd_pkg::W_BITS]),
        .i_centre (r_win[wwpd_pkg::CENTRE]),
        .i_margin (r_margin),
        .i_sample (r_win[tap]),
        .o_acc    (acc)
    );

    assign i_smp.ready = ctl.in_ready;
    assign i_cfg.ready = i_rst_n;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps   <= wwpd_pkg::TAPS_RESET;
            r_margin <= wwpd_pkg::MARGIN_RESET;
        end else if (i_cfg.valid) begin
            case (wwpd_pkg::t_cfg_idx'(i_cfg.index))
                wwpd_pkg::CFG_TAP_WEIGHTS: r_taps   <= i_cfg.data[wwpd_pkg::TAPS_W-1:0];
                wwpd_pkg::CFG_PEAK_MARGIN: r_margin <= i_cfg.data[wwpd_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Window and context advance inside the profile cut; last mark taken on every sample.
    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_last <= i_smp.last;
            if (active) begin
                for (int i = 0; i < wwpd_pkg::WINDOW - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[wwpd_pkg::WINDOW-1] <= i_smp.sample;
                r_conf   <= r_pend[1];
                r_centre <= centre_pos[wwpd_pkg::INDEX_W-1:0];
            end else begin
                r_conf <= 1'b0;
            end
        end
    end

    // Profile state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_peaks     <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load the slot on a new result, otherwise drop it once transferred.
            if (ctl.emit && need_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ctl.accept && active) begin
                r_pos   <= r_pos + 1'b1;
                r_peaks <= r_peaks + wwpd_pkg::COUNT_W'(r_pend[1]);
                r_pend  <= {r_pend[0], 1'b0};
            end
            if (ctl.emit) begin
                if (r_last) begin
                    // Drop profile state after the final sample.
                    r_pos   <= '0;
                    r_peaks <= '0;
                    r_pend  <= '0;
                end else begin
                    r_pend[0] <= verdict;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit && need_out) begin
            r_is_peak <= r_conf;
            r_index   <= r_conf ? r_centre : '0;
            r_eop     <= r_last;
            r_total   <= r_peaks;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.is_peak        = r_is_peak;
    assign o_res.peak_index     = r_index;
    assign o_res.end_of_profile = r_eop;
    assign o_res.peak_total     = r_total;

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= wwpd_pkg::POS_W'(wwpd_pkg::MAX_LEN))
        else $error("profile position past cut");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("ready right after a sample transfer");

    a_peak_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_peak) |-> (o_res.peak_total != '0))
        else $error("peak reported with zero total");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.is_peak) |-> (o_res.peak_index == '0))
        else $error("index set without a peak");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.emit && need_out) |-> (!r_out_valid || o_res.ready))
        else $error("result overwrote a held result");
`endif

endmodule
